// ===== hdl/tip_pkg.sv =====
// Shared types and constants for the text-to-integer parser.
package tip_pkg;

    localparam int INDEX_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int VALUE_BITS     = 64;
    localparam int END_INDEX_BITS = 16;
    localparam int RADIX_BITS     = 6;
    localparam int DIGIT_BITS     = 6;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 6;

    localparam logic [CFG_INDEX_BITS-1:0] REG_RADIX       = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SIGNED_MODE = 1'd1;

    localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_BITS-1:0] BASE_AUTO   = 6'd0;
    localparam logic [RADIX_BITS-1:0] BASE_ONE    = 6'd1;
    localparam logic [RADIX_BITS-1:0] BASE_OCT    = 6'd8;
    localparam logic [RADIX_BITS-1:0] BASE_DEC    = 6'd10;
    localparam logic [RADIX_BITS-1:0] BASE_HEX    = 6'd16;
    localparam logic [RADIX_BITS-1:0] BASE_MAX    = 6'd36;

    // classified character word, front to back
    typedef struct packed {
        logic                  start;
        logic                  bad_base;
        logic [RADIX_BITS-1:0] base;
        logic                  is_digit;
        logic [DIGIT_BITS-1:0] digit;
        logic                  is_space;
        logic                  is_plus;
        logic                  is_minus;
        logic                  is_zero;
        logic                  is_x;
    } tip_class_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]     value;
        logic [END_INDEX_BITS-1:0] end_index;
        logic                      minus_seen;
        logic                      base_error;
    } tip_result_t;

endpackage

// ===== hdl/text_to_integer_parser.sv =====
// Top level of the streaming text-to-integer parser.
// One character is accepted per clock, sustained, as long as results are drained; the
// rate is set by the parse engine, which does one 64-bit multiply-add by the base per
// character. A character passes the classify register, a short word queue and the
// parse engine, and the result for a terminating character is written into the output
// queue. Radix and signed_mode are written through the cfg port (index 0 radix, index 1
// signed_mode); the user must write them only while the parser is quiet, which the block itself does not enforce.
module text_to_integer_parser
    import tip_pkg::*;
#(
    parameter int INDEX_BITS  = INDEX_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      start_req,
    input  logic [7:0]                char_code,
    output logic                      empty,
    input  logic                      pop,
    output logic [VALUE_BITS-1:0]     value,
    output logic [END_INDEX_BITS-1:0] end_index,
    output logic                      minus_seen,
    output logic                      base_error,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic [RADIX_BITS-1:0] radix_reg;
    logic                  signed_mode_reg;

    logic        fr_valid;
    tip_class_t  fr_word;
    logic        fr_taken;
    logic        wq_full;
    logic        wq_empty;
    tip_class_t  wq_word;
    logic        wq_pop;
    logic        res_push;
    tip_result_t res_in;
    tip_result_t res_out;
    logic        rq_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg       <= RADIX_RESET;
            signed_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RADIX:       radix_reg       <= cfg_data[RADIX_BITS-1:0];
                REG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign fr_taken = fr_valid && !wq_full;

    tip_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .start_req  (start_req),
        .char_code  (char_code),
        .radix      (radix_reg),
        .word_valid (fr_valid),
        .word       (fr_word),
        .word_taken (fr_taken)
    );

    tip_fifo #(
        .WIDTH ($bits(tip_class_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_word_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fr_taken),
        .wr_data  (fr_word),
        .rd_en    (wq_pop),
        .rd_data  (wq_word),
        .is_full  (wq_full),
        .is_empty (wq_empty)
    );

    tip_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .word_valid  (!wq_empty),
        .word        (wq_word),
        .word_pop    (wq_pop),
        .signed_mode (signed_mode_reg),
        .res_push    (res_push),
        .res         (res_in),
        .res_full    (rq_full)
    );

    tip_fifo #(
        .WIDTH ($bits(tip_result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (res_push),
        .wr_data  (res_in),
        .rd_en    (pop),
        .rd_data  (res_out),
        .is_full  (rq_full),
        .is_empty (empty)
    );

    assign value      = res_out.value;
    assign end_index  = res_out.end_index;
    assign minus_seen = res_out.minus_seen;
    assign base_error = res_out.base_error;

endmodule

// ===== hdl/tip_fifo.sv =====
// Small register-based first-in first-out queue.
module tip_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             is_full,
    output logic             is_empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_wr;
    logic                do_rd;

    assign is_full  = (count_reg == CNT_BITS'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign do_wr    = wr_en && !is_full;
    assign do_rd    = rd_en && !is_empty;
    assign rd_data  = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        if (p == PTR_BITS'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_BITS'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_BITS'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/tip_front.sv =====
// Input stage: takes characters and classifies them into digit/space/sign flags.
module tip_front
    import tip_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  start_req,
    input  logic [7:0]            char_code,
    input  logic [RADIX_BITS-1:0] radix,
    output logic                  word_valid,
    output tip_class_t            word,
    input  logic                  word_taken
);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7a;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_X     = 8'h78;

    logic       valid_reg;
    tip_class_t word_reg;
    tip_class_t word_next;
    logic       accept;
    logic [7:0] rel;

    assign full       = valid_reg && !word_taken;
    assign accept     = push && !full;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_comb
    begin
        word_next          = '0;
        rel                = '0;
        word_next.start    = start_req;
        word_next.base     = radix;
        word_next.bad_base = (radix == BASE_ONE) || (radix > BASE_MAX);
        if (char_code inside {[CH_ZERO:CH_NINE]})
        begin
            rel                = char_code - CH_ZERO;
            word_next.is_digit = 1'b1;
            word_next.digit    = rel[DIGIT_BITS-1:0];
        end
        else if (char_code inside {[CH_LA:CH_LZ]})
        begin
            rel                = char_code - CH_LA + 8'd10;
            word_next.is_digit = 1'b1;
            word_next.digit    = rel[DIGIT_BITS-1:0];
        end
        else if (char_code inside {[CH_UA:CH_UZ]})
        begin
            rel                = char_code - CH_UA + 8'd10;
            word_next.is_digit = 1'b1;
            word_next.digit    = rel[DIGIT_BITS-1:0];
        end
        word_next.is_space = (char_code inside {[CH_TAB:CH_CR]}) || (char_code == CH_SPACE);
        word_next.is_plus  = (char_code == CH_PLUS);
        word_next.is_minus = (char_code == CH_MINUS);
        word_next.is_zero  = (char_code == CH_ZERO);
        word_next.is_x     = (char_code == CH_X);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (word_taken)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ===== hdl/tip_back.sv =====
// Parse engine: prefix/sign handling and the multiply-add accumulator.
module tip_back
    import tip_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        word_valid,
    input  tip_class_t  word,
    output logic        word_pop,
    input  logic        signed_mode,
    output logic        res_push,
    output tip_result_t res,
    input  logic        res_full
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    phase_t                  phase_reg, phase_next, cur_phase;
    logic [RADIX_BITS-1:0]   base_reg, base_next, cur_base, eff_base;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next, cur_acc;
    logic                    minus_reg, minus_next, cur_minus;
    logic [INDEX_BITS-1:0]   idx_reg, idx_next, cur_idx, idx_inc;
    logic                    do_prefix;
    logic                    do_try;
    logic                    emit;

    assign word_pop = word_valid && !res_full;
    assign res_push = word_pop && emit;

    always_comb
    begin
        cur_phase  = word.start ? PH_SPACE : phase_reg;
        cur_base   = word.start ? word.base : base_reg;
        cur_acc    = word.start ? '0 : acc_reg;
        cur_minus  = word.start ? 1'b0 : minus_reg;
        cur_idx    = word.start ? '0 : idx_reg;
        idx_inc    = (cur_idx == '1) ? cur_idx : cur_idx + INDEX_BITS'(1);

        phase_next = cur_phase;
        base_next  = cur_base;
        acc_next   = cur_acc;
        minus_next = cur_minus;
        idx_next   = cur_idx;
        eff_base   = cur_base;
        do_prefix  = 1'b0;
        do_try     = 1'b0;
        emit       = 1'b0;
        res        = '0;

        if (word.start && word.bad_base)
        begin
            emit           = 1'b1;
            res.base_error = 1'b1;
            phase_next     = PH_IDLE;
        end
        else
        begin
            case (cur_phase)
                PH_SPACE:
                begin
                    if (word.is_space)
                    begin
                        idx_next = idx_inc;
                    end
                    else if (word.is_plus || word.is_minus)
                    begin
                        minus_next = word.is_minus;
                        phase_next = PH_SIGNED;
                        idx_next   = idx_inc;
                    end
                    else
                    begin
                        do_prefix = 1'b1;
                    end
                end
                PH_SIGNED:
                begin
                    do_prefix = 1'b1;
                end
                PH_ZERO:
                begin
                    if (word.is_x)
                    begin
                        base_next  = BASE_HEX;
                        phase_next = PH_DIGITS;
                        idx_next   = idx_inc;
                    end
                    else
                    begin
                        eff_base = (cur_base == BASE_AUTO) ? BASE_OCT : cur_base;
                        do_try   = 1'b1;
                    end
                end
                PH_DIGITS:
                begin
                    do_try = 1'b1;
                end
                default:
                begin
                end
            endcase

            if (do_prefix)
            begin
                if ((cur_base == BASE_AUTO || cur_base == BASE_HEX) && word.is_zero)
                begin
                    acc_next   = '0;
                    phase_next = PH_ZERO;
                    idx_next   = idx_inc;
                end
                else
                begin
                    eff_base = (cur_base == BASE_AUTO) ? BASE_DEC : cur_base;
                    do_try   = 1'b1;
                end
            end

            if (do_try)
            begin
                base_next = eff_base;
                if (word.is_digit && (word.digit < eff_base))
                begin
                    acc_next   = cur_acc * VALUE_BITS'(eff_base)
                               + VALUE_BITS'(word.digit);
                    phase_next = PH_DIGITS;
                    idx_next   = idx_inc;
                end
                else
                begin
                    emit           = 1'b1;
                    res.value      = (signed_mode && cur_minus) ? ('0 - cur_acc) : cur_acc;
                    res.end_index  = END_INDEX_BITS'(cur_idx);
                    res.minus_seen = cur_minus;
                    phase_next     = PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            base_reg  <= '0;
            acc_reg   <= '0;
            minus_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (word_pop)
        begin
            phase_reg <= phase_next;
            base_reg  <= base_next;
            acc_reg   <= acc_next;
            minus_reg <= minus_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== hdl/tip_checker.sv =====
// Port-level checks for the text-to-integer parser, bound to the top level.
module tip_checker
    import tip_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      full,
    input logic                      empty,
    input logic                      pop,
    input logic [VALUE_BITS-1:0]     value,
    input logic [END_INDEX_BITS-1:0] end_index,
    input logic                      minus_seen,
    input logic                      base_error,
    input logic                      cfg_ready
);

    a_empty_in_reset: assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("result queue not empty during reset");

    a_error_word_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && base_error) |-> (value == '0 && end_index == '0 && !minus_seen))
        else $error("base error word carries parse data");

    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg port not ready");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(value) && $stable(end_index)))
        else $error("waiting result changed before pop");

endmodule

bind text_to_integer_parser tip_checker u_tip_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for text_to_integer_parser: character stream in, parsed numbers checked.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tip_pkg::*;

    typedef enum logic [2:0] {SCAN_IDLE, SCAN_SPACE, SCAN_SIGN, SCAN_ZERO, SCAN_DIGITS}
        scan_phase_t;

    localparam int         NO_DIGIT  = 255;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_TOP    = 8'd255;
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_ZERO   = "0";
    localparam logic [7:0] CH_NINE   = "9";
    localparam logic [7:0] CH_LA     = "a";
    localparam logic [7:0] CH_LZ     = "z";
    localparam logic [7:0] CH_UA     = "A";
    localparam logic [7:0] CH_UZ     = "Z";
    localparam logic [7:0] CH_X      = "x";

    class number_scoreboard;
        logic [RADIX_BITS-1:0]     radix_reg  = RADIX_RESET;
        logic                      signed_reg = 1'b0;
        scan_phase_t               phase      = SCAN_IDLE;
        logic [RADIX_BITS-1:0]     base       = '0;
        logic [VALUE_BITS-1:0]     acc        = '0;
        logic                      minus      = 1'b0;
        logic [END_INDEX_BITS-1:0] pos        = '0;
        tip_result_t               pending_numbers[$];
        int                        mismatches = 0;

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_RADIX)
                radix_reg = data[RADIX_BITS-1:0];
            else if (idx == REG_SIGNED_MODE)
                signed_reg = data[0];
        endfunction

        function int digit_value(logic [7:0] c);
            if (c >= CH_ZERO && c <= CH_NINE)
                return int'(c - CH_ZERO);
            if (c >= CH_LA && c <= CH_LZ)
                return 10 + int'(c - CH_LA);
            if (c >= CH_UA && c <= CH_UZ)
                return 10 + int'(c - CH_UA);
            return NO_DIGIT;
        endfunction

        function void bump();
            if (pos != '1)
                pos = pos + 1'b1;
        endfunction

        function void take_digit(logic [7:0] c);
            int          d;
            tip_result_t r;
            d = digit_value(c);
            if (d < int'(base))
            begin
                acc   = acc * VALUE_BITS'(base) + VALUE_BITS'(d);
                phase = SCAN_DIGITS;
                bump();
            end
            else
            begin
                r.value      = (signed_reg && minus) ? -acc : acc;
                r.end_index  = pos;
                r.minus_seen = minus;
                r.base_error = 1'b0;
                pending_numbers.push_back(r);
                phase = SCAN_IDLE;
            end
        endfunction

        // a leading zero may open a hex prefix or an octal number
        function void prefix_point(logic [7:0] c);
            if ((base == BASE_AUTO || base == BASE_HEX) && c == CH_ZERO)
            begin
                acc   = '0;
                phase = SCAN_ZERO;
                bump();
            end
            else
            begin
                if (base == BASE_AUTO)
                    base = BASE_DEC;
                take_digit(c);
            end
        endfunction

        function void note_char(logic s, logic [7:0] c);
            tip_result_t r;
            if (s)
            begin
                base  = radix_reg;
                acc   = '0;
                minus = 1'b0;
                pos   = '0;
                if (base == BASE_ONE || base > BASE_MAX)
                begin
                    r.value      = '0;
                    r.end_index  = '0;
                    r.minus_seen = 1'b0;
                    r.base_error = 1'b1;
                    pending_numbers.push_back(r);
                    phase = SCAN_IDLE;
                    return;
                end
                phase = SCAN_SPACE;
            end
            case (phase)
                SCAN_SPACE:
                    if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE)
                        bump();
                    else if (c == CH_PLUS || c == CH_MINUS)
                    begin
                        minus = (c == CH_MINUS);
                        phase = SCAN_SIGN;
                        bump();
                    end
                    else
                        prefix_point(c);
                SCAN_SIGN:
                    prefix_point(c);
                SCAN_ZERO:
                    if (c == CH_X)
                    begin
                        base  = BASE_HEX;
                        phase = SCAN_DIGITS;
                        bump();
                    end
                    else
                    begin
                        if (base == BASE_AUTO)
                            base = BASE_OCT;
                        take_digit(c);
                    end
                SCAN_DIGITS:
                    take_digit(c);
                default:
                    ;
            endcase
        endfunction

        function void check_number(tip_result_t got);
            tip_result_t want;
            if (pending_numbers.size() == 0)
            begin
                $display("%0t: unexpected word, value %h end_index %0d", $time, got.value,
                         got.end_index);
                mismatches++;
                return;
            end
            want = pending_numbers.pop_front();
            if (got.value !== want.value)
            begin
                $display("%0t: value expected %h got %h", $time, want.value, got.value);
                mismatches++;
            end
            if (got.end_index !== want.end_index)
            begin
                $display("%0t: end_index expected %0d got %0d", $time, want.end_index,
                         got.end_index);
                mismatches++;
            end
            if (got.minus_seen !== want.minus_seen)
            begin
                $display("%0t: minus_seen expected %b got %b", $time, want.minus_seen,
                         got.minus_seen);
                mismatches++;
            end
            if (got.base_error !== want.base_error)
            begin
                $display("%0t: base_error expected %b got %b", $time, want.base_error,
                         got.base_error);
                mismatches++;
            end
        endfunction
    endclass

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      push       = 1'b0;
    logic                      full;
    logic                      start_req  = 1'b0;
    logic [7:0]                char_code  = '0;
    logic                      empty;
    logic                      pop        = 1'b0;
    logic [VALUE_BITS-1:0]     value;
    logic [END_INDEX_BITS-1:0] end_index;
    logic                      minus_seen;
    logic                      base_error;
    logic                      cfg_valid  = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index  = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data   = '0;

    number_scoreboard sb = new;
    bit               steady = 1'b0;

    logic [RADIX_BITS-1:0] radix_plan [9] = '{BASE_AUTO, BASE_MAX, 6'd2, BASE_HEX, 6'd63,
                                              BASE_OCT, BASE_ONE, BASE_DEC, 6'd37};

    text_to_integer_parser u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .start_req  (start_req),
        .char_code  (char_code),
        .empty      (empty),
        .pop        (pop),
        .value      (value),
        .end_index  (end_index),
        .minus_seen (minus_seen),
        .base_error (base_error),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] digit_char(int d);
        if (d < 10)
            return CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d - 10);
    endfunction

    // push stays high between back-to-back words and drops only for a gap
    task automatic send_char(input logic s, input logic [7:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        start_req <= s;
        char_code <= c;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_char(s, c);
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++)
            send_char(i == 0, t[i]);
    endtask

    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending_numbers.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [RADIX_BITS-1:0] r, input logic s);
        settle();
        write_reg(REG_RADIX, r);
        write_reg(REG_SIGNED_MODE, {{(CFG_DATA_BITS-1){1'b0}}, s});
    endtask

    task automatic random_string(output int used);
        logic [7:0] text[$];
        int         b;
        int         n;
        used = 0;
        if ($urandom_range(0, 99) < 10)
        begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                send_char(i == 0 || $urandom_range(0, 15) == 0, 8'($urandom_range(0, 255)));
            used = n;
            return;
        end
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        for (int i = 0; i < n; i++)
            text.push_back(($urandom_range(0, 5) == 5) ? CH_SPACE
                                                        : 8'($urandom_range(9, 13)));
        case ($urandom_range(0, 3))
            0: text.push_back(CH_PLUS);
            1: text.push_back(CH_MINUS);
            default: ;
        endcase
        b = int'(sb.radix_reg);
        if (b == int'(BASE_AUTO))
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    text.push_back(CH_ZERO);
                    text.push_back(CH_X);
                    b = 16;
                end
                1:
                begin
                    text.push_back(CH_ZERO);
                    b = 8;
                end
                default:
                begin
                    text.push_back(digit_char($urandom_range(1, 9)));
                    b = 10;
                end
            endcase
        end
        else if (b == int'(BASE_HEX) && $urandom_range(0, 1))
        begin
            text.push_back(CH_ZERO);
            text.push_back(CH_X);
        end
        if (b < 2 || b > int'(BASE_MAX))
            b = 10;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 25) : $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
            text.push_back(digit_char($urandom_range(0, b - 1)));
        case ($urandom_range(0, 7))
            0: text.push_back(CH_NUL);
            1: text.push_back(CH_TOP);
            2: text.push_back(CH_SPACE);
            3: text.push_back(CH_MINUS);
            4: ;
            default: text.push_back(8'($urandom_range(0, 255)));
        endcase
        repeat ($urandom_range(0, 2)) text.push_back(8'($urandom_range(0, 255)));
        used = text.size();
        foreach (text[i])
            send_char(i == 0, text[i]);
    endtask

    // result side: random stalls on pop, checked at each accepting edge
    initial
    begin
        int stall_left;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_number('{value, end_index, minus_seen, base_error});
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                pop <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap();
                pop <= (stall_left == 0);
            end
        end
    end

    initial
    begin
        int items;
        int used;
        int strings;
        int k;
        items   = 0;
        strings = 0;
        k       = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sign after sign ends the string; trailing digit is ignored while idle
        send_text("\x0c-+5");
        configure(BASE_AUTO, 1'b1);
        send_text("0x1fG");
        send_text("017\xff");
        configure(BASE_HEX, 1'b0);
        send_text("0x");
        send_char(1'b0, CH_NUL);
        configure(BASE_MAX, 1'b1);
        send_text("zZ.");
        send_text("9");
        send_text("-1 ");
        configure(BASE_ONE, 1'b0);
        send_char(1'b1, "7");
        configure(6'd63, 1'b0);
        send_char(1'b1, "5");
        // base is held from the start word, signed_mode is taken at the end
        configure(BASE_DEC, 1'b0);
        send_text("-12");
        configure(BASE_HEX, 1'b1);
        send_char(1'b0, "3");
        send_char(1'b0, "g");

        while (items < 1250)
        begin
            if (strings % 16 == 15)
            begin
                if (k < 9)
                    configure(radix_plan[k], k[0]);
                else if ($urandom_range(0, 9) == 0)
                    configure(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
                else
                    configure(radix_plan[$urandom_range(0, 8)], 1'($urandom_range(0, 1)));
                k++;
            end
            if ($urandom_range(0, 19) == 0)
                steady = !steady;
            random_string(used);
            items += used;
            strings++;
        end

        settle();
        repeat (10) @(posedge clk);
        if (sb.pending_numbers.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, sb.pending_numbers.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("text_to_integer_parser verification clean");
        else
            $display("text_to_integer_parser verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("%0t: timeout", $time);
        $display("text_to_integer_parser verification failed");
        $finish;
    end

endmodule
